// ===== rtl/core/cfcc_pkg.sv =====
`timescale 1ns / 1ps

package cfcc_pkg;

  // input field and result field widths
  localparam int unsigned ADJ_WIDTH    = 29;
  localparam int unsigned MAG_WIDTH    = 28;
  localparam int unsigned PERIOD_WIDTH = 30;

  // saturation limit for the adjustment magnitude, nanoseconds per second
  localparam logic [MAG_WIDTH-1:0] MAX_ADJ_PPB = MAG_WIDTH'(250000000);
  localparam longint unsigned      NS_PER_SEC  = 64'd1000000000;

  // restoring divider produces one quotient bit per step
  localparam int unsigned DIV_STEPS = PERIOD_WIDTH;
  localparam int unsigned CNT_WIDTH = $clog2(DIV_STEPS);

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SEARCH,
    ST_DIV,
    ST_FINISH
  } cfcc_state_t;

endpackage

// ===== rtl/core/cfcc_cmp_sub.sv =====
`timescale 1ns / 1ps

module cfcc_cmp_sub #(
  parameter int unsigned W = 37
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] diff,
  output logic         ge
);

  logic [W:0] full;

  // one subtractor, the borrow gives the compare
  assign full = {1'b0, a} - {1'b0, b};
  assign diff = full[W-1:0];
  assign ge   = ~full[W];

endmodule

// ===== rtl/core/clock_frequency_correction_calc_top.sv =====
`timescale 1ns / 1ps

// Frequency correction calculator for a time-stamp counter.
// Input channel (in_valid/in_ready/in_adjust_ppb) takes a signed adjustment
// in parts per billion. Result channel (out_valid/out_ready) returns one
// transaction per input: out_updated, out_corrected_increment and
// out_correction_period (period minus one when above one).
// Config channel (cfg_valid/cfg_ready/cfg_data) writes the nominal increment;
// it is taken only while the sequencer is idle.
// Timing: one transaction is worked at a time. After acceptance the
// sequencer passes through a multiply state, a search over candidate
// steps (step is ceil(|ppb| * increment / 1e9), at most a quarter
// of the increment rounded up), the bit-serial divider and a finish
// state, where the result is loaded and out_valid raised. A zero
// adjustment goes straight to the finish state; a zero increment ends
// the search at its first candidate, with no division. in_ready returns
// once the result is loaded. Search and divider compares share one subtractor.
// Reset loads the nominal increment with 8 and leaves the block idle with
// no result pending. A finished result sits in the output register until
// taken; the next input is accepted meanwhile, and a second result waits
// in the finish cycle, holding in_ready low, while the receiver stalls.
module clock_frequency_correction_calc_top #(
  parameter int unsigned INCREMENT_BITS = 7
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [cfcc_pkg::ADJ_WIDTH-1:0] in_adjust_ppb,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [INCREMENT_BITS-1:0]            cfg_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_updated,
  output logic [INCREMENT_BITS:0]              out_corrected_increment,
  output logic [cfcc_pkg::PERIOD_WIDTH-1:0]    out_correction_period
);

  localparam int unsigned PW = cfcc_pkg::MAG_WIDTH + INCREMENT_BITS;
  localparam int unsigned LW = INCREMENT_BITS + cfcc_pkg::PERIOD_WIDTH;
  localparam int unsigned QW = cfcc_pkg::PERIOD_WIDTH;
  localparam logic [INCREMENT_BITS-1:0] INC_RST = INCREMENT_BITS'(8);
  localparam logic [LW-1:0] NS_STEP = LW'(cfcc_pkg::NS_PER_SEC);

  cfcc_pkg::cfcc_state_t state_r, state_nxt;

  logic [INCREMENT_BITS-1:0]       inc_r;
  logic [cfcc_pkg::MAG_WIDTH-1:0]  mag_r, mag_nxt;
  logic                            neg_r, neg_nxt;
  logic                            zero_r, zero_nxt;
  logic [PW-1:0]                   prod_r, prod_nxt;
  logic [LW-1:0]                   lhs_r, lhs_nxt;
  logic [INCREMENT_BITS:0]         idx_r, idx_nxt;
  logic [INCREMENT_BITS-1:0]       step_r, step_nxt;
  logic [PW-1:0]                   rem_r, rem_nxt;
  logic [QW-1:0]                   quo_r, quo_nxt;
  logic [cfcc_pkg::CNT_WIDTH-1:0]  cnt_r, cnt_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic                            out_updated_r;
  logic [INCREMENT_BITS:0]         out_corr_r;
  logic [QW-1:0]                   out_period_r;

  logic                            in_fire;
  logic                            load_out;
  logic                            div_last;

  logic [cfcc_pkg::ADJ_WIDTH-1:0]  raw;
  logic [cfcc_pkg::ADJ_WIDTH-1:0]  mag_full;
  logic [PW:0]                     shifted;
  logic [LW-1:0]                   unit_a, unit_b, unit_diff;
  logic                            unit_ge;

  logic [INCREMENT_BITS:0]         corr_val;
  logic [QW-1:0]                   period_val;

  // shared compare and subtract unit
  cfcc_cmp_sub #(
    .W(LW)
  ) u_cmp_sub (
    .a   (unit_a),
    .b   (unit_b),
    .diff(unit_diff),
    .ge  (unit_ge)
  );

  // magnitude of the incoming adjustment, saturated when it is registered
  assign raw      = in_adjust_ppb;
  assign mag_full = raw[cfcc_pkg::ADJ_WIDTH-1] ? (~raw + 1'b1) : raw;

  // divider shift: remainder with the next dividend bit
  assign shifted = {rem_r, quo_r[QW-1]};

  // operand select for the shared unit
  always_comb begin
    unit_b = LW'(prod_r);
    if (state_r == cfcc_pkg::ST_DIV) begin
      unit_a = LW'(shifted);
    end else begin
      unit_a = lhs_r;
    end
  end

  assign div_last = (cnt_r == cfcc_pkg::CNT_WIDTH'(cfcc_pkg::DIV_STEPS - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cfcc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (mag_full == '0) ? cfcc_pkg::ST_FINISH : cfcc_pkg::ST_MUL;
        end
      end
      cfcc_pkg::ST_MUL: begin
        state_nxt = cfcc_pkg::ST_SEARCH;
      end
      cfcc_pkg::ST_SEARCH: begin
        if (idx_r > {1'b0, inc_r}) begin
          state_nxt = cfcc_pkg::ST_FINISH;
        end else if (unit_ge) begin
          state_nxt = cfcc_pkg::ST_DIV;
        end
      end
      cfcc_pkg::ST_DIV: begin
        if (div_last) begin
          state_nxt = cfcc_pkg::ST_FINISH;
        end
      end
      cfcc_pkg::ST_FINISH: begin
        if (load_out) begin
          state_nxt = cfcc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cfcc_pkg::ST_IDLE;
      end
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready  = 1'b0;
    cfg_ready = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      cfcc_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cfg_ready = 1'b1;
      end
      cfcc_pkg::ST_FINISH: begin
        load_out = ~out_valid_r | out_ready;
      end
      default: begin
        in_ready  = 1'b0;
        cfg_ready = 1'b0;
        load_out  = 1'b0;
      end
    endcase
  end

  assign in_fire = in_valid & in_ready;

  // datapath next values
  always_comb begin
    mag_nxt  = mag_r;
    neg_nxt  = neg_r;
    zero_nxt = zero_r;
    prod_nxt = prod_r;
    lhs_nxt  = lhs_r;
    idx_nxt  = idx_r;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    case (state_r)
      cfcc_pkg::ST_IDLE: begin
        if (in_fire) begin
          neg_nxt  = raw[cfcc_pkg::ADJ_WIDTH-1];
          zero_nxt = (mag_full == '0);
          if (mag_full > cfcc_pkg::ADJ_WIDTH'(cfcc_pkg::MAX_ADJ_PPB)) begin
            mag_nxt = cfcc_pkg::MAX_ADJ_PPB;
          end else begin
            mag_nxt = mag_full[cfcc_pkg::MAG_WIDTH-1:0];
          end
          quo_nxt = '0;
        end
      end
      cfcc_pkg::ST_MUL: begin
        prod_nxt = PW'(mag_r) * PW'(inc_r);
        lhs_nxt  = NS_STEP;
        idx_nxt  = (INCREMENT_BITS + 1)'(1);
      end
      cfcc_pkg::ST_SEARCH: begin
        if (idx_r > {1'b0, inc_r}) begin
          // no step fits: full increment, period of one
          step_nxt = inc_r;
          quo_nxt  = QW'(1);
        end else if (unit_ge) begin
          step_nxt = idx_r[INCREMENT_BITS-1:0];
          rem_nxt  = PW'(lhs_r >> QW);
          quo_nxt  = lhs_r[QW-1:0];
          cnt_nxt  = '0;
        end else begin
          lhs_nxt = lhs_r + NS_STEP;
          idx_nxt = idx_r + 1'b1;
        end
      end
      cfcc_pkg::ST_DIV: begin
        // restoring division, one quotient bit per cycle
        if (unit_ge) begin
          rem_nxt = unit_diff[PW-1:0];
        end else begin
          rem_nxt = shifted[PW-1:0];
        end
        quo_nxt = {quo_r[QW-2:0], unit_ge};
        cnt_nxt = cnt_r + 1'b1;
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  // result assembly
  always_comb begin
    if (zero_r) begin
      corr_val = '0;
    end else if (neg_r) begin
      corr_val = {1'b0, inc_r} - {1'b0, step_r};
    end else begin
      corr_val = {1'b0, inc_r} + {1'b0, step_r};
    end
    if (quo_r > QW'(1)) begin
      period_val = quo_r - 1'b1;
    end else begin
      period_val = quo_r;
    end
  end

  assign out_valid_nxt = load_out | (out_valid_r & ~out_ready);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cfcc_pkg::ST_IDLE;
      inc_r       <= INC_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        inc_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
    prod_r <= prod_nxt;
    lhs_r  <= lhs_nxt;
    idx_r  <= idx_nxt;
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    cnt_r  <= cnt_nxt;
    if (load_out) begin
      out_updated_r <= ~zero_r;
      out_corr_r    <= corr_val;
      out_period_r  <= period_val;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_updated             = out_updated_r;
  assign out_corrected_increment = out_corr_r;
  assign out_correction_period   = out_period_r;

endmodule
